// ===== hdl/gdg_pkg.sv =====
// shared types, constants and codes of the ground elevation grid
package gdg_pkg;

  localparam int CoordW    = 24;
  localparam int DeltaW    = 25;
  localparam int CfgW      = 16;
  localparam int RegIdxW   = 3;
  localparam int HagW      = 23;
  localparam int ProdW     = 26;
  localparam int Dist2W    = 50;
  localparam int DivNumW   = 27;
  localparam int DivDenW   = 17;
  localparam int QuoW      = 28;
  localparam int SqrtInW   = 54;
  localparam int RootW     = 27;
  localparam int DistW     = 25;
  localparam int IterN     = 27;
  localparam int IterCntW  = 5;

  localparam int GRID_WIDTH_DEF = 101;

  localparam logic signed [CoordW-1:0] HeightLimitMm = 24'sd1000000;
  localparam logic [HagW-1:0]          HagMax        = 23'h7FFFFF;

  localparam logic [CfgW-1:0] CellSizeRst    = 16'd400;
  localparam logic [CfgW-1:0] LowerBoundRst  = 16'hFA24;
  localparam logic [CfgW-1:0] UpperBoundRst  = 16'd1000;
  localparam logic [CfgW-1:0] SlopeRatioRst  = 16'd6554;
  localparam logic [CfgW-1:0] VehHeightRst   = 16'd1500;
  localparam logic [CfgW-1:0] LocalRadiusRst = 16'd4000;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_ACCUM = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_CELL_SIZE    = 3'd0,
    REG_LOWER_BOUND  = 3'd1,
    REG_UPPER_BOUND  = 3'd2,
    REG_SLOPE_RATIO  = 3'd3,
    REG_VEH_HEIGHT   = 3'd4,
    REG_LOCAL_RADIUS = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_ITER,
    ST_SLOPE,
    ST_WIN,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_RD,
    ST_QRY_DATA,
    ST_QRY_OUT
  } state_e;

  typedef struct packed {
    logic                     filled;
    logic signed [CoordW-1:0] ground;
  } cell_t;

  typedef struct packed {
    logic load;
    logic step;
  } iter_ctrl_t;

endpackage

// ===== hdl/gdg_cell_mem.sv =====
// cell memory: one write port, one registered read port
module gdg_cell_mem #(
  parameter int Depth = gdg_pkg::GRID_WIDTH_DEF * gdg_pkg::GRID_WIDTH_DEF,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  gdg_pkg::cell_t       wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output gdg_pkg::cell_t       rdata_o
);

  gdg_pkg::cell_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/gdg_div.sv =====
// iterative restoring divider giving a floored signed quotient
module gdg_div (
  input  logic                                clk_i,
  input  gdg_pkg::iter_ctrl_t                 ctrl_i,
  input  logic signed [gdg_pkg::DivNumW-1:0]  num_i,
  input  logic [gdg_pkg::DivDenW-1:0]         den_i,
  output logic signed [gdg_pkg::QuoW-1:0]     quo_o
);

  logic [gdg_pkg::DivNumW-1:0] mag_q;
  logic [gdg_pkg::DivDenW-1:0] rem_q;
  logic [gdg_pkg::DivDenW-1:0] den_q;
  logic                        neg_q;
  logic [gdg_pkg::DivDenW:0]   trial;
  logic                        fits;
  logic signed [gdg_pkg::QuoW-1:0] pos_quo;

  assign trial = {rem_q, mag_q[gdg_pkg::DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q <= num_i[gdg_pkg::DivNumW-1] ? gdg_pkg::DivNumW'(-num_i)
                                         : gdg_pkg::DivNumW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[gdg_pkg::DivNumW-1];
    end else if (ctrl_i.step) begin
      rem_q <= fits ? gdg_pkg::DivDenW'(trial - {1'b0, den_q})
                    : gdg_pkg::DivDenW'(trial);
      mag_q <= {mag_q[gdg_pkg::DivNumW-2:0], fits};
    end
  end

  // floor for negative numerators
  assign pos_quo = $signed({1'b0, mag_q});
  assign quo_o   = neg_q ? (-pos_quo - ((rem_q != '0) ? 28'sd1 : 28'sd0)) : pos_quo;

endmodule

// ===== hdl/gdg_sqrt.sv =====
// iterative integer square root, one result bit per step
module gdg_sqrt (
  input  logic                             clk_i,
  input  gdg_pkg::iter_ctrl_t              ctrl_i,
  input  logic [gdg_pkg::Dist2W-1:0]       n_i,
  output logic [gdg_pkg::DistW-1:0]        root_o
);

  logic [gdg_pkg::SqrtInW-1:0] n_q;
  logic [gdg_pkg::RootW:0]     rem_q;
  logic [gdg_pkg::RootW-1:0]   root_q;
  logic [gdg_pkg::RootW+2:0]   trial;
  logic [gdg_pkg::RootW+2:0]   sub;
  logic                        fits;

  assign trial = {rem_q, n_q[gdg_pkg::SqrtInW-1 -: 2]};
  assign sub   = {1'b0, root_q, 2'b01};
  assign fits  = trial >= sub;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      n_q    <= {{(gdg_pkg::SqrtInW - gdg_pkg::Dist2W){1'b0}}, n_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q  <= fits ? (gdg_pkg::RootW+1)'(trial - sub) : (gdg_pkg::RootW+1)'(trial);
      root_q <= {root_q[gdg_pkg::RootW-2:0], fits};
      n_q    <= {n_q[gdg_pkg::SqrtInW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[gdg_pkg::DistW-1:0];

endmodule

// ===== hdl/ground_elevation_grid.sv =====
// top level: grid of minimum ground heights around the vehicle
//
// Items enter on the s_axis channel: tuser carries the kind, tdata x, y, z.
// A frame start stores the vehicle pose and starts a clearing pass over all
// GRID_WIDTH*GRID_WIDTH cells, one cell a cycle; no item is taken during it.
// Reset starts the same pass.
// An accumulate or query item goes through squaring on a shared 13x13
// multiplier, then 27 steps in which the square root and both cell-index
// dividers run side by side, then window scaling.
// An accumulate inside the window and below the height limit then walks the
// nine neighbour cells through the cell memory (read, then write back), and
// skips those outside the grid. A query reads its cell, if in the grid, and
// puts one result into the output register; m_axis tuser carries keep and
// in_grid, tdata the height above ground.
// One item is worked at a time. A new item is taken while a result still
// waits in the output register; a query that finishes while the receiver
// stalls waits until that register frees.
// Configuration writes on the cfg channel are taken in any cycle.
module ground_elevation_grid #(
  parameter int GRID_WIDTH = gdg_pkg::GRID_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // pos_x_mm, pos_y_mm, pos_z_mm
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // height_above_ground_mm, zero pad
  output logic [1:0]  m_axis_tuser,   // keep, in_grid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [gdg_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [gdg_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int CellCount = GRID_WIDTH * GRID_WIDTH;
  localparam int AddrW     = $clog2(CellCount);
  localparam int IdxW      = $clog2(GRID_WIDTH);
  localparam int Half      = (GRID_WIDTH - 1) / 2;
  localparam int QuoW      = gdg_pkg::QuoW;
  localparam int CoordW    = gdg_pkg::CoordW;
  localparam int DeltaW    = gdg_pkg::DeltaW;
  localparam int WinW      = 27;

  gdg_pkg::state_e state_q, state_d;

  logic [gdg_pkg::CfgW-1:0] cell_size_q, lower_q, upper_q, slope_q, veh_h_q, radius_q;
  logic signed [CoordW-1:0] veh_x_q, veh_y_q, veh_z_q;

  logic [AddrW-1:0]            clr_q;
  logic [2:0]                  mul_cnt_q;
  logic [gdg_pkg::IterCntW-1:0] iter_cnt_q;
  logic signed [1:0]           ox_q, oy_q;
  logic                        m_valid_q;

  gdg_pkg::kind_e              kind_q;
  logic signed [CoordW-1:0]    z_q;
  logic signed [DeltaW-1:0]    dx_q, dy_q, dz_q;
  logic [gdg_pkg::Dist2W-1:0]  acc_q;
  logic [31:0]                 rsq_q;
  logic [gdg_pkg::DistW-1:0]   w_q;
  logic signed [QuoW-1:0]      ix_q, iy_q;
  logic                        window_q;
  logic [AddrW-1:0]            addr_q;
  logic                        res_keep_q, res_in_q;
  logic [gdg_pkg::HagW-1:0]    res_hag_q;
  logic                        out_keep_q, out_in_q;
  logic [gdg_pkg::HagW-1:0]    out_hag_q;

  logic in_xfer, cfg_xfer;
  gdg_pkg::kind_e in_kind;
  logic signed [CoordW-1:0] in_x, in_y, in_z;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign in_kind  = gdg_pkg::kind_e'(s_axis_tuser);
  assign in_x     = $signed(s_axis_tdata[23:0]);
  assign in_y     = $signed(s_axis_tdata[47:24]);
  assign in_z     = $signed(s_axis_tdata[71:48]);
  assign cfg_ready_o = 1'b1;

  // squaring on a shared multiplier
  logic [DeltaW-1:0] abs_x, abs_y, abs_sel;
  logic [12:0]       op_a, op_b;
  logic [gdg_pkg::ProdW-1:0]  prod;
  logic [gdg_pkg::Dist2W-1:0] addend;

  assign abs_x   = dx_q[DeltaW-1] ? DeltaW'(-dx_q) : DeltaW'(dx_q);
  assign abs_y   = dy_q[DeltaW-1] ? DeltaW'(-dy_q) : DeltaW'(dy_q);
  assign abs_sel = (mul_cnt_q < 3'd3) ? abs_x : abs_y;

  always_comb begin
    op_a   = {1'b0, abs_sel[24:13]};
    op_b   = {1'b0, abs_sel[24:13]};
    case (mul_cnt_q)
      3'd1, 3'd4: begin
        op_b = abs_sel[12:0];
      end
      3'd2, 3'd5: begin
        op_a = abs_sel[12:0];
        op_b = abs_sel[12:0];
      end
      default: begin
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    case (mul_cnt_q)
      3'd0, 3'd3: addend = gdg_pkg::Dist2W'(prod) << 26;
      3'd1, 3'd4: addend = gdg_pkg::Dist2W'(prod) << 14;
      default:    addend = gdg_pkg::Dist2W'(prod);
    endcase
  end

  // iterative units
  gdg_pkg::iter_ctrl_t iter_ctrl;
  logic [gdg_pkg::DivDenW-1:0] den;
  logic [gdg_pkg::CfgW-1:0]    cs_eff;
  logic signed [gdg_pkg::DivNumW-1:0] num_x, num_y;
  logic signed [QuoW-1:0] quo_x, quo_y;
  logic [gdg_pkg::DistW-1:0] dist_mm;

  assign cs_eff = (cell_size_q == '0) ? 16'd1 : cell_size_q;
  assign den    = {cs_eff, 1'b0};
  assign num_x  = (gdg_pkg::DivNumW'(dx_q) <<< 1) + $signed({11'b0, cs_eff});
  assign num_y  = (gdg_pkg::DivNumW'(dy_q) <<< 1) + $signed({11'b0, cs_eff});

  gdg_div u_div_x (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .num_i  (num_x),
    .den_i  (den),
    .quo_o  (quo_x)
  );

  gdg_div u_div_y (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .num_i  (num_y),
    .den_i  (den),
    .quo_o  (quo_y)
  );

  gdg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .n_i    (acc_q),
    .root_o (dist_mm)
  );

  // window and neighbour cell
  logic [40:0] slope_prod;
  logic signed [WinW-1:0] win_lo, win_hi, dz_w;
  logic window;
  logic signed [QuoW-1:0] cx, cy;
  logic nb_in, nb_last;
  logic [AddrW-1:0] nb_addr;

  assign slope_prod = slope_q * dist_mm;
  assign dz_w   = WinW'(dz_q);
  assign win_lo = WinW'($signed(lower_q)) - $signed({2'b0, w_q});
  assign win_hi = WinW'($signed(upper_q)) + $signed({2'b0, w_q});
  assign window = (dz_w > win_lo) && (dz_w < win_hi);

  assign cx = ix_q + QuoW'(ox_q);
  assign cy = iy_q + QuoW'(oy_q);
  assign nb_in = (cx >= 0) && (cx < QuoW'(GRID_WIDTH)) &&
                 (cy >= 0) && (cy < QuoW'(GRID_WIDTH));
  assign nb_addr = AddrW'(cx[IdxW-1:0]) * AddrW'(GRID_WIDTH) + AddrW'(cy[IdxW-1:0]);
  assign nb_last = (ox_q == 2'sd1) && (oy_q == 2'sd1);

  // cell memory
  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  gdg_pkg::cell_t mem_wdata, mem_rdata;
  logic upd_take;

  assign upd_take = !mem_rdata.filled || (z_q < mem_rdata.ground);

  gdg_cell_mem #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (nb_addr),
    .rdata_o (mem_rdata)
  );

  // query result
  logic signed [DeltaW-1:0] q_ground, q_diff;
  logic [DeltaW-1:0] q_abs;

  assign q_ground = mem_rdata.filled ? DeltaW'(mem_rdata.ground) : '0;
  assign q_diff   = DeltaW'(z_q) - q_ground;
  assign q_abs    = q_diff[DeltaW-1] ? DeltaW'(-q_diff) : DeltaW'(q_diff);

  // control
  logic out_load, nb_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdg_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    iter_ctrl = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '{filled: 1'b1, ground: z_q};
    out_load  = 1'b0;
    nb_adv    = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      gdg_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{filled: 1'b0, ground: '0};
        if (clr_q == AddrW'(CellCount - 1)) state_d = gdg_pkg::ST_IDLE;
      end
      gdg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          case (in_kind)
            gdg_pkg::KIND_FRAME: state_d = gdg_pkg::ST_CLEAR;
            gdg_pkg::KIND_ACCUM, gdg_pkg::KIND_QUERY: state_d = gdg_pkg::ST_MUL;
            default: state_d = gdg_pkg::ST_IDLE;
          endcase
        end
      end
      gdg_pkg::ST_MUL: begin
        if (mul_cnt_q == 3'd5) state_d = gdg_pkg::ST_LOAD;
      end
      gdg_pkg::ST_LOAD: begin
        iter_ctrl.load = 1'b1;
        state_d = gdg_pkg::ST_ITER;
      end
      gdg_pkg::ST_ITER: begin
        iter_ctrl.step = 1'b1;
        if (iter_cnt_q == gdg_pkg::IterCntW'(gdg_pkg::IterN - 1)) state_d = gdg_pkg::ST_SLOPE;
      end
      gdg_pkg::ST_SLOPE: begin
        state_d = gdg_pkg::ST_WIN;
      end
      gdg_pkg::ST_WIN: begin
        if (kind_q == gdg_pkg::KIND_QUERY) begin
          state_d = gdg_pkg::ST_QRY_RD;
        end else if (window && (z_q < gdg_pkg::HeightLimitMm)) begin
          state_d = gdg_pkg::ST_UPD_RD;
        end else begin
          state_d = gdg_pkg::ST_IDLE;
        end
      end
      gdg_pkg::ST_UPD_RD: begin
        if (nb_in) begin
          mem_re  = 1'b1;
          state_d = gdg_pkg::ST_UPD_WR;
        end else begin
          nb_adv = 1'b1;
          if (nb_last) state_d = gdg_pkg::ST_IDLE;
        end
      end
      gdg_pkg::ST_UPD_WR: begin
        mem_we  = upd_take;
        nb_adv  = 1'b1;
        state_d = nb_last ? gdg_pkg::ST_IDLE : gdg_pkg::ST_UPD_RD;
      end
      gdg_pkg::ST_QRY_RD: begin
        if (nb_in) begin
          mem_re  = 1'b1;
          state_d = gdg_pkg::ST_QRY_DATA;
        end else begin
          state_d = gdg_pkg::ST_QRY_OUT;
        end
      end
      gdg_pkg::ST_QRY_DATA: begin
        state_d = gdg_pkg::ST_QRY_OUT;
      end
      gdg_pkg::ST_QRY_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = gdg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gdg_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= gdg_pkg::CellSizeRst;
      lower_q     <= gdg_pkg::LowerBoundRst;
      upper_q     <= gdg_pkg::UpperBoundRst;
      slope_q     <= gdg_pkg::SlopeRatioRst;
      veh_h_q     <= gdg_pkg::VehHeightRst;
      radius_q    <= gdg_pkg::LocalRadiusRst;
      veh_x_q     <= '0;
      veh_y_q     <= '0;
      veh_z_q     <= '0;
      clr_q       <= '0;
      mul_cnt_q   <= '0;
      iter_cnt_q  <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (gdg_pkg::reg_idx_e'(cfg_index_i))
          gdg_pkg::REG_CELL_SIZE:    cell_size_q <= cfg_data_i;
          gdg_pkg::REG_LOWER_BOUND:  lower_q     <= cfg_data_i;
          gdg_pkg::REG_UPPER_BOUND:  upper_q     <= cfg_data_i;
          gdg_pkg::REG_SLOPE_RATIO:  slope_q     <= cfg_data_i;
          gdg_pkg::REG_VEH_HEIGHT:   veh_h_q     <= cfg_data_i;
          gdg_pkg::REG_LOCAL_RADIUS: radius_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_xfer && (in_kind == gdg_pkg::KIND_FRAME)) begin
        veh_x_q <= in_x;
        veh_y_q <= in_y;
        veh_z_q <= in_z;
      end
      if (state_q == gdg_pkg::ST_CLEAR) begin
        clr_q <= (state_d == gdg_pkg::ST_CLEAR) ? clr_q + 1'b1 : '0;
      end
      mul_cnt_q  <= (state_q == gdg_pkg::ST_MUL) ? mul_cnt_q + 3'd1 : '0;
      iter_cnt_q <= (state_q == gdg_pkg::ST_ITER) ? iter_cnt_q + 1'b1 : '0;
      if (state_q == gdg_pkg::ST_WIN) begin
        ox_q <= (kind_q == gdg_pkg::KIND_QUERY) ? 2'sd0 : -2'sd1;
        oy_q <= (kind_q == gdg_pkg::KIND_QUERY) ? 2'sd0 : -2'sd1;
      end else if (nb_adv) begin
        if (oy_q == 2'sd1) begin
          oy_q <= -2'sd1;
          ox_q <= ox_q + 2'sd1;
        end else begin
          oy_q <= oy_q + 2'sd1;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= in_kind;
      z_q    <= in_z;
      dx_q   <= DeltaW'(in_x) - DeltaW'(veh_x_q);
      dy_q   <= DeltaW'(in_y) - DeltaW'(veh_y_q);
      dz_q   <= DeltaW'(in_z) - DeltaW'(veh_z_q);
      acc_q  <= '0;
    end else if (state_q == gdg_pkg::ST_MUL) begin
      acc_q  <= acc_q + addend;
    end
    if (state_q == gdg_pkg::ST_LOAD) begin
      rsq_q <= radius_q * radius_q;
    end
    if (state_q == gdg_pkg::ST_SLOPE) begin
      w_q  <= slope_prod[40:16];
      ix_q <= quo_x + QuoW'(Half);
      iy_q <= quo_y + QuoW'(Half);
    end
    if (state_q == gdg_pkg::ST_WIN) begin
      window_q <= window;
    end
    if (mem_re) begin
      addr_q <= nb_addr;
    end
    if (state_q == gdg_pkg::ST_QRY_RD) begin
      res_keep_q <= 1'b0;
      res_hag_q  <= '0;
      res_in_q   <= 1'b0;
    end else if (state_q == gdg_pkg::ST_QRY_DATA) begin
      res_in_q   <= 1'b1;
      res_hag_q  <= (q_abs > DeltaW'(gdg_pkg::HagMax)) ? gdg_pkg::HagMax
                                                        : q_abs[gdg_pkg::HagW-1:0];
      res_keep_q <= window_q && (acc_q > gdg_pkg::Dist2W'(rsq_q)) &&
                    (q_abs < DeltaW'(veh_h_q));
    end
    if (out_load) begin
      out_keep_q <= res_keep_q;
      out_hag_q  <= res_hag_q;
      out_in_q   <= res_in_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_hag_q};
  assign m_axis_tuser  = {out_in_q, out_keep_q};

  // checks
  a_keep_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("keep set for a point outside the grid");

  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> kind_q == gdg_pkg::KIND_QUERY)
    else $error("result loaded for an item that is not a query");

  a_upd_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q == gdg_pkg::ST_UPD_WR |-> mem_wdata.filled &&
    z_q < gdg_pkg::HeightLimitMm)
    else $error("cell update without fill or above the height limit");

  a_no_same_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != nb_addr)
    else $error("read and write of one cell in the same cycle");

endmodule
